// ----- rtl/ssc_pkg.sv -----
// Shared types and constants for the SHA-256 midstate stamp scorer.
// No dependencies; imported by every module of the block.
package ssc_pkg;

	typedef logic [31:0] word_t;

	// Payload of one round stage: working variables a..h (index 0 = a)
	// and the sliding 16-word message schedule window (index 0 = oldest).
	typedef struct packed {
		word_t [15:0] w;
		word_t [7:0]  st;
	} rnd_t;

	// Configuration register indexes
	localparam logic [2:0] RegChainA    = 3'd0;
	localparam logic [2:0] RegChainB    = 3'd1;
	localparam logic [2:0] RegChainC    = 3'd2;
	localparam logic [2:0] RegChainD    = 3'd3;
	localparam logic [2:0] RegPriorLen  = 3'd4;
	localparam logic [2:0] RegMidValid  = 3'd5;
	localparam logic [2:0] RegTarget    = 3'd6;

	localparam int unsigned NumRounds = 64;

	// SHA-256 round constants
	localparam word_t RoundK [NumRounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ----- rtl/sha256_midstate_stamp_scorer.sv -----
// Pipeline: 1 load stage, 64 round stages and 3 scoring stages from input
// transfer to result valid. Throughput: one stamp per cycle while not stalled.
// The whole pipeline advances together; it stalls only while a result
// waits at the output and out_ready is low.
// Reset (arst_n, asynchronous) clears all valid bits and the config registers.
// Top level; depends on ssc_pkg, ssc_round and ssc_score.
module sha256_midstate_stamp_scorer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] stamp_bytes_0_7,
	input  logic [63:0] stamp_bytes_8_15,
	input  logic [63:0] stamp_bytes_16_23,
	input  logic [63:0] stamp_bytes_24_31,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [8:0]  zero_bit_count,
	output logic        meets_target
);
	import ssc_pkg::*;

	logic [63:0] chain_a_q, chain_b_q, chain_c_q, chain_d_q;
	logic [47:0] prior_len_q;
	logic        mid_valid_q;
	logic [8:0]  target_q;

	word_t [7:0] chain;
	logic [48:0] total_len;
	logic        en;

	logic        ld_valid_s0;
	rnd_t        ld_data_s0;
	rnd_t        ld_nxt;

	logic        stg_valid [NumRounds + 1];
	rnd_t        stg_data  [NumRounds + 1];

	// Global advance: the output register is free or being taken
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_a_q   <= '0;
			chain_b_q   <= '0;
			chain_c_q   <= '0;
			chain_d_q   <= '0;
			prior_len_q <= '0;
			mid_valid_q <= 1'b0;
			target_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				RegChainA:   chain_a_q   <= cfg_wdata;
				RegChainB:   chain_b_q   <= cfg_wdata;
				RegChainC:   chain_c_q   <= cfg_wdata;
				RegChainD:   chain_d_q   <= cfg_wdata;
				RegPriorLen: prior_len_q <= cfg_wdata[47:0];
				RegMidValid: mid_valid_q <= cfg_wdata[0];
				RegTarget:   target_q    <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		chain[0] = chain_a_q[63:32];
		chain[1] = chain_a_q[31:0];
		chain[2] = chain_b_q[63:32];
		chain[3] = chain_b_q[31:0];
		chain[4] = chain_c_q[63:32];
		chain[5] = chain_c_q[31:0];
		chain[6] = chain_d_q[63:32];
		chain[7] = chain_d_q[31:0];
	end

	// Message block: stamp, pad word, zero fill, 64-bit length
	always_comb begin
		total_len    = {1'b0, prior_len_q} + 49'd256;
		ld_nxt.st    = chain;
		ld_nxt.w[0]  = stamp_bytes_0_7[63:32];
		ld_nxt.w[1]  = stamp_bytes_0_7[31:0];
		ld_nxt.w[2]  = stamp_bytes_8_15[63:32];
		ld_nxt.w[3]  = stamp_bytes_8_15[31:0];
		ld_nxt.w[4]  = stamp_bytes_16_23[63:32];
		ld_nxt.w[5]  = stamp_bytes_16_23[31:0];
		ld_nxt.w[6]  = stamp_bytes_24_31[63:32];
		ld_nxt.w[7]  = stamp_bytes_24_31[31:0];
		ld_nxt.w[8]  = 32'h8000_0000;
		ld_nxt.w[9]  = '0;
		ld_nxt.w[10] = '0;
		ld_nxt.w[11] = '0;
		ld_nxt.w[12] = '0;
		ld_nxt.w[13] = '0;
		ld_nxt.w[14] = {15'd0, total_len[48:32]};
		ld_nxt.w[15] = total_len[31:0];
	end

	// Load stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_valid_s0 <= 1'b0;
		end else if (en) begin
			ld_valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ld_data_s0 <= ld_nxt;
		end
	end

	assign stg_valid[0] = ld_valid_s0;
	assign stg_data[0]  = ld_data_s0;

	// 64 round stages
	for (genvar r = 0; r < NumRounds; r++) begin : g_round
		ssc_round u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (stg_valid[r]),
			.in_data   (stg_data[r]),
			.k_word    (RoundK[r]),
			.out_valid (stg_valid[r + 1]),
			.out_data  (stg_data[r + 1])
		);
	end

	ssc_score u_score (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (stg_valid[NumRounds]),
		.st        (stg_data[NumRounds].st),
		.chain     (chain),
		.mid_valid (mid_valid_q),
		.target    (target_q),
		.out_valid (out_valid),
		.count     (zero_bit_count),
		.meets     (meets_target)
	);

endmodule

// ----- rtl/ssc_round.sv -----
// One registered SHA-256 compression round plus one message schedule step.
// Depends on ssc_pkg.
module ssc_round (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  ssc_pkg::rnd_t in_data,
	input  ssc_pkg::word_t k_word,
	output logic          out_valid,
	output ssc_pkg::rnd_t out_data
);
	import ssc_pkg::*;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	word_t a, b, c, d, e, f, g, h;
	word_t big_s0, big_s1, ch, maj, t1, t2;
	word_t sm_s0, sm_s1, w_next;
	rnd_t  nxt;
	logic  valid_s1;
	rnd_t  data_s1;

	// Round datapath
	always_comb begin
		a = in_data.st[0];
		b = in_data.st[1];
		c = in_data.st[2];
		d = in_data.st[3];
		e = in_data.st[4];
		f = in_data.st[5];
		g = in_data.st[6];
		h = in_data.st[7];
		big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
		big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
		ch     = (e & f) ^ (~e & g);
		maj    = (a & b) ^ (a & c) ^ (b & c);
		t1     = h + big_s1 + ch + k_word + in_data.w[0];
		t2     = big_s0 + maj;
		nxt.st[0] = t1 + t2;
		nxt.st[1] = a;
		nxt.st[2] = b;
		nxt.st[3] = c;
		nxt.st[4] = d + t1;
		nxt.st[5] = e;
		nxt.st[6] = f;
		nxt.st[7] = g;
	end

	// Schedule window slides by one word
	always_comb begin
		sm_s0  = rotr(in_data.w[1], 7) ^ rotr(in_data.w[1], 18) ^ (in_data.w[1] >> 3);
		sm_s1  = rotr(in_data.w[14], 17) ^ rotr(in_data.w[14], 19) ^ (in_data.w[14] >> 10);
		w_next = in_data.w[0] + sm_s0 + in_data.w[9] + sm_s1;
		for (int j = 0; j < 15; j++) begin
			nxt.w[j] = in_data.w[j + 1];
		end
		nxt.w[15] = w_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ----- rtl/ssc_score.sv -----
// Final digest add, leading zero count and target compare (three stages).
// Depends on ssc_pkg.
module ssc_score (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  ssc_pkg::word_t [7:0] st,
	input  ssc_pkg::word_t [7:0] chain,
	input  logic                 mid_valid,
	input  logic [8:0]           target,
	output logic                 out_valid,
	output logic [8:0]           count,
	output logic                 meets
);
	import ssc_pkg::*;

	function automatic logic [5:0] lzc32(input word_t v);
		logic [5:0] n;
		n = 6'd32;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				n = 6'(31 - i);
			end
		end
		lzc32 = n;
	endfunction

	logic                valid_s1, valid_s2, valid_q;
	word_t [7:0]         dig_s1;
	logic  [7:0][5:0]    lz_s2;
	logic  [8:0]         total;
	logic  [8:0]         cnt_q;
	logic                meet_q;

	// Combine per-word counts: stop at the first word that is not all zero; total is 0 while mid_valid is low
	always_comb begin
		logic done;
		done  = 1'b0;
		total = 9'd0;
		for (int i = 0; i < 8; i++) begin
			if (!done) begin
				total = total + {3'd0, lz_s2[i]};
				if (lz_s2[i] != 6'd32) begin
					done = 1'b1;
				end
			end
		end
		if (!mid_valid) begin
			total = 9'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	// Digest add, per-word counts, result register
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 8; i++) begin
				dig_s1[i] <= chain[i] + st[i];
				lz_s2[i]  <= lzc32(dig_s1[i]);
			end
			cnt_q  <= total;
			meet_q <= (total >= target);
		end
	end

	assign out_valid = valid_q;
	assign count     = cnt_q;
	assign meets     = meet_q;

endmodule
